>>> hdl/ddmut_pkg.sv
package ddmut_pkg;

    localparam int DIST_W   = 14;
    localparam int PERIOD_W = 10;

    localparam logic [DIST_W-1:0]   DIST_MAX     = 14'd9999;
    localparam logic [PERIOD_W-1:0] SONAR_RESET  = 10'd1000;
    localparam logic [PERIOD_W-1:0] BUTTON_RESET = 10'd200;

    // 0.393701 in unsigned Q0.20, with the half-LSB rounding term.
    localparam logic [18:0] INCH_Q20   = 19'd412826;
    localparam logic [32:0] INCH_ROUND = 33'd524288;

    // Reciprocals for exact floor division of values up to 9999.
    localparam logic [15:0] RECIP_1000 = 16'd8389;
    localparam logic [15:0] RECIP_100  = 16'd5243;
    localparam logic [15:0] RECIP_10   = 16'd52429;

    // Configuration register indexes.
    localparam logic REG_SONAR_PERIOD  = 1'b0;
    localparam logic REG_BUTTON_PERIOD = 1'b1;

    // Digit positions.
    localparam logic [1:0] SEL_THOUSANDS = 2'd0;
    localparam logic [1:0] SEL_HUNDREDS  = 2'd1;
    localparam logic [1:0] SEL_TENS      = 2'd2;
    localparam logic [1:0] SEL_UNITS     = 2'd3;

    typedef struct packed {
        logic [DIST_W-1:0] value;
        logic [1:0]        sel;
        logic              inch;
    } t_word;

endpackage

>>> hdl/ddmut_sched.sv
module ddmut_sched (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_addr,
    input  logic [ddmut_pkg::PERIOD_W-1:0]     i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [ddmut_pkg::DIST_W-1:0]       i_distance_cm,
    input  logic                               i_button_pressed,
    output logic                               o_valid,
    input  logic                               i_ready,
    output ddmut_pkg::t_word                   o_word
);

    logic [ddmut_pkg::PERIOD_W-1:0] r_sonar_period, r_button_period;
    logic [ddmut_pkg::PERIOD_W-1:0] r_sonar_elapsed, r_button_elapsed;
    logic [ddmut_pkg::DIST_W-1:0]   r_latched, n_latched;
    logic                           r_unit, n_unit;
    logic                           r_wait, n_wait;
    logic [1:0]                     r_digit;
    logic                           r_started;
    logic                           r_valid;
    ddmut_pkg::t_word               r_word;
    logic                           accept, sonar_fire, button_fire;

    assign o_ready     = !r_valid || i_ready;
    assign accept      = i_valid && o_ready;
    assign sonar_fire  = r_sonar_elapsed >= r_sonar_period;
    assign button_fire = r_button_elapsed >= r_button_period;

    always_comb begin
        n_latched = r_latched;
        if (sonar_fire) begin
            n_latched = (i_distance_cm > ddmut_pkg::DIST_MAX) ? ddmut_pkg::DIST_MAX
                                                              : i_distance_cm;
        end
        n_unit = r_unit;
        n_wait = r_wait;
        // Toggle once per press, then hold off until the button is seen released.
        if (button_fire) begin
            if (!r_wait) begin
                if (i_button_pressed) begin
                    n_unit = !r_unit;
                    n_wait = 1'b1;
                end
            end else if (!i_button_pressed) begin
                n_wait = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sonar_period   <= ddmut_pkg::SONAR_RESET;
            r_button_period  <= ddmut_pkg::BUTTON_RESET;
            r_sonar_elapsed  <= '0;
            r_button_elapsed <= '0;
            r_latched        <= '0;
            r_unit           <= 1'b0;
            r_wait           <= 1'b0;
            r_digit          <= ddmut_pkg::SEL_THOUSANDS;
            r_started        <= 1'b0;
            r_valid          <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    ddmut_pkg::REG_SONAR_PERIOD:  r_sonar_period  <= i_cfg_data;
                    ddmut_pkg::REG_BUTTON_PERIOD: r_button_period <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                r_sonar_elapsed  <= sonar_fire  ? 10'd1 : r_sonar_elapsed + 10'd1;
                r_button_elapsed <= button_fire ? 10'd1 : r_button_elapsed + 10'd1;
                r_latched        <= n_latched;
                r_unit           <= n_unit;
                r_wait           <= n_wait;
                r_started        <= 1'b1;
                if (r_started) begin
                    r_digit <= r_digit + 2'd1;
                end
            end
            if (o_ready) begin
                r_valid <= accept && r_started;
            end
        end
    end

    // The digit sees this tick's latch but the unit flag from before this tick.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word.value <= n_latched;
            r_word.sel   <= r_digit;
            r_word.inch  <= r_unit;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

>>> hdl/ddmut_conv.sv
module ddmut_conv (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  ddmut_pkg::t_word i_word,
    output logic             o_valid,
    input  logic             i_ready,
    output ddmut_pkg::t_word o_word
);

    logic             r_valid;
    ddmut_pkg::t_word r_word;
    logic [32:0]      product;
    logic [ddmut_pkg::DIST_W-1:0] inches;

    assign o_ready = !r_valid || i_ready;
    assign product = 33'(i_word.value) * 33'(ddmut_pkg::INCH_Q20) + ddmut_pkg::INCH_ROUND;
    assign inches  = {1'b0, product[32:20]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word.value <= i_word.inch ? inches : i_word.value;
            r_word.sel   <= i_word.sel;
            r_word.inch  <= i_word.inch;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

>>> hdl/ddmut_digit.sv
module ddmut_digit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  ddmut_pkg::t_word i_word,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [3:0]       o_digit_value,
    output logic [1:0]       o_digit_select,
    output logic             o_in_inches
);

    // First stage: quotient by the place value of the selected position.
    logic             r_q_valid;
    ddmut_pkg::t_word r_q;
    logic             q_ready;
    logic [29:0]      prod_q;
    logic [ddmut_pkg::DIST_W-1:0] quot;

    // Second stage: quotient modulo ten.
    logic        r_valid;
    logic [3:0]  r_digit;
    logic [1:0]  r_sel;
    logic        r_inch;
    logic [29:0] prod_10;
    logic [10:0] q10;
    logic [ddmut_pkg::DIST_W-1:0] q10x10, rem;

    assign q_ready = !r_valid || i_ready;
    assign o_ready = !r_q_valid || q_ready;

    always_comb begin
        prod_q = '0;
        quot   = i_word.value;
        unique case (i_word.sel)
            ddmut_pkg::SEL_THOUSANDS: begin
                prod_q = 30'(i_word.value) * 30'(ddmut_pkg::RECIP_1000);
                quot   = {7'd0, prod_q[29:23]};
            end
            ddmut_pkg::SEL_HUNDREDS: begin
                prod_q = 30'(i_word.value) * 30'(ddmut_pkg::RECIP_100);
                quot   = {3'd0, prod_q[29:19]};
            end
            ddmut_pkg::SEL_TENS: begin
                prod_q = 30'(i_word.value) * 30'(ddmut_pkg::RECIP_10);
                quot   = {3'd0, prod_q[29:19]};
            end
            ddmut_pkg::SEL_UNITS: begin
                quot   = i_word.value;
            end
            default: ;
        endcase
    end

    assign prod_10 = 30'(r_q.value) * 30'(ddmut_pkg::RECIP_10);
    assign q10     = prod_10[29:19];
    assign q10x10  = {q10, 3'b000} + {2'b00, q10, 1'b0};
    assign rem     = r_q.value - q10x10;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_valid <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            if (o_ready) begin
                r_q_valid <= i_valid;
            end
            if (q_ready) begin
                r_valid <= r_q_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_q.value <= quot;
            r_q.sel   <= i_word.sel;
            r_q.inch  <= i_word.inch;
        end
        if (q_ready && r_q_valid) begin
            r_digit <= rem[3:0];
            r_sel   <= r_q.sel;
            r_inch  <= r_q.inch;
        end
    end

    assign o_valid        = r_valid;
    assign o_digit_value  = r_digit;
    assign o_digit_select = r_sel;
    assign o_in_inches    = r_inch;

endmodule

>>> hdl/distance_display_mux_with_unit_toggle.sv
// Four-digit multiplexed distance display driver with a centimeter/inch toggle. Each input
// word is one scheduler tick carrying the measured distance and the button level; the block
// latches the distance every sonar_period ticks, samples the button every button_period ticks
// and toggles the unit on a press, and from the second tick on emits one digit word per tick,
// cycling thousands, hundreds, tens and units. A word is accepted every cycle while the output
// drains. A tick passes four register stages: the tick scheduler, loaded at the edge that
// accepts the tick, the inch conversion multiplier, the place-value divide and the final
// modulo-ten step, whose register presents its digit. Configuration writes take effect on
// the next clock edge.
module distance_display_mux_with_unit_toggle (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_addr,
    input  logic [ddmut_pkg::PERIOD_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [ddmut_pkg::DIST_W-1:0]   i_distance_cm,
    input  logic                           i_button_pressed,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [3:0]                     o_digit_value,
    output logic [1:0]                     o_digit_select,
    output logic                           o_in_inches
);

    logic             sched_valid, sched_ready;
    ddmut_pkg::t_word sched_word;
    logic             conv_valid, conv_ready;
    ddmut_pkg::t_word conv_word;

    ddmut_sched u_sched (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_distance_cm    (i_distance_cm),
        .i_button_pressed (i_button_pressed),
        .o_valid          (sched_valid),
        .i_ready          (sched_ready),
        .o_word           (sched_word)
    );

    ddmut_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sched_valid),
        .o_ready (sched_ready),
        .i_word  (sched_word),
        .o_valid (conv_valid),
        .i_ready (conv_ready),
        .o_word  (conv_word)
    );

    ddmut_digit u_digit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (conv_valid),
        .o_ready        (conv_ready),
        .i_word         (conv_word),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_digit_value  (o_digit_value),
        .o_digit_select (o_digit_select),
        .o_in_inches    (o_in_inches)
    );

    // Tracks the position of the last delivered digit for the sequence check.
    logic       r_seen;
    logic [1:0] r_prev_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (o_valid && i_ready) begin
            r_seen <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_valid && i_ready) begin
            r_prev_sel <= o_digit_select;
        end
    end

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_digit_value <= 4'd9)
        else $error("digit value out of decimal range");

    a_inch_thousands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_in_inches && o_digit_select == ddmut_pkg::SEL_THOUSANDS
        |-> o_digit_value <= 4'd3)
        else $error("inch value exceeds converted maximum");

    a_select_sequence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_seen |-> o_digit_select == r_prev_sel + 2'd1)
        else $error("digit positions out of order");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

>>> sim/distance_display_mux_with_unit_toggle_tb.sv
`timescale 1ns / 100ps

module distance_display_mux_with_unit_toggle_tb;

    localparam int              DIST_W         = ddmut_pkg::DIST_W;
    localparam int              PERIOD_W       = ddmut_pkg::PERIOD_W;
    localparam int unsigned     WATCHDOG_LIMIT = 5000;
    localparam int unsigned     DRAIN_CYCLES   = 8;
    localparam logic [63:0]     INCH_SCALE     = 64'd412826;
    localparam logic [63:0]     INCH_HALF      = 64'd524288;

    typedef struct packed {
        logic [DIST_W-1:0] cm;
        logic              btn;
    } t_tick;

    typedef struct packed {
        logic [3:0] value;
        logic [1:0] sel;
        logic       inch;
    } t_digit;

    logic                i_clk            = 1'b0;
    logic                i_rst_n          = 1'b0;
    logic                i_cfg_we         = 1'b0;
    logic                i_cfg_addr       = ddmut_pkg::REG_SONAR_PERIOD;
    logic [PERIOD_W-1:0] i_cfg_data       = '0;
    logic                i_valid          = 1'b0;
    logic                o_ready;
    logic [DIST_W-1:0]   i_distance_cm    = '0;
    logic                i_button_pressed = 1'b0;
    logic                o_valid;
    logic                i_ready          = 1'b0;
    logic [3:0]          o_digit_value;
    logic [1:0]          o_digit_select;
    logic                o_in_inches;

    distance_display_mux_with_unit_toggle i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_distance_cm    (i_distance_cm),
        .i_button_pressed (i_button_pressed),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_digit_value    (o_digit_value),
        .o_digit_select   (o_digit_select),
        .o_in_inches      (o_in_inches)
    );

    always #5 i_clk = ~i_clk;

    t_tick  tick_q[$];
    t_digit digit_q[$];

    int unsigned ticks_queued  = 0;
    int unsigned ticks_taken   = 0;
    int unsigned digits_seen   = 0;
    int unsigned inch_digits   = 0;
    int unsigned unit_toggles  = 0;
    int unsigned cfg_writes    = 0;
    int unsigned n_err         = 0;

    // Shadow copy of the scheduler state and its two period registers.
    logic [PERIOD_W-1:0] sonar_per     = ddmut_pkg::SONAR_RESET;
    logic [PERIOD_W-1:0] button_per    = ddmut_pkg::BUTTON_RESET;
    logic [PERIOD_W-1:0] sonar_cnt     = '0;
    logic [PERIOD_W-1:0] button_cnt    = '0;
    logic [DIST_W-1:0]   held_cm       = '0;
    logic                inch_mode     = 1'b0;
    logic                await_release = 1'b0;
    logic [1:0]          digit_pos     = ddmut_pkg::SEL_THOUSANDS;
    logic                shown_any     = 1'b0;

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int unsigned pick_gap(input bit burst);
        int unsigned r;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // One scheduler tick: sonar latch, then the displayed digit, then the button.
    task automatic predict_tick(input t_tick t);
        t_digit          d;
        logic [DIST_W-1:0] shown;
        logic [63:0]     prod;
        if (sonar_cnt >= sonar_per) begin
            held_cm   = (t.cm > ddmut_pkg::DIST_MAX) ? ddmut_pkg::DIST_MAX : t.cm;
            sonar_cnt = '0;
        end
        sonar_cnt = sonar_cnt + 1'b1;

        if (shown_any) begin
            shown = held_cm;
            if (inch_mode) begin
                prod  = 64'(held_cm) * INCH_SCALE + INCH_HALF;
                shown = DIST_W'(prod >> 20);
            end
            case (digit_pos)
                ddmut_pkg::SEL_THOUSANDS: d.value = 4'((shown / 1000) % 10);
                ddmut_pkg::SEL_HUNDREDS:  d.value = 4'((shown / 100) % 10);
                ddmut_pkg::SEL_TENS:      d.value = 4'((shown / 10) % 10);
                default:                  d.value = 4'(shown % 10);
            endcase
            d.sel     = digit_pos;
            d.inch    = inch_mode;
            digit_pos = digit_pos + 1'b1;
            digit_q.push_back(d);
        end
        shown_any = 1'b1;

        // A toggle here only shows up on the next tick's digit.
        if (button_cnt >= button_per) begin
            if (!await_release) begin
                if (t.btn) begin
                    inch_mode     = ~inch_mode;
                    await_release = 1'b1;
                    unit_toggles++;
                end
            end else if (!t.btn) begin
                await_release = 1'b0;
            end
            button_cnt = '0;
        end
        button_cnt = button_cnt + 1'b1;
    endtask

    // Driver: feeds ticks from the queue and keeps the shadow state in step.
    int unsigned tx_gap   = 0;
    bit          tx_burst = 1'b0;

    always @(posedge i_clk) begin
        t_tick t;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == ddmut_pkg::REG_SONAR_PERIOD)
                    sonar_per = i_cfg_data;
                else
                    button_per = i_cfg_data;
            end
            if (i_valid && o_ready) begin
                predict_tick('{cm: i_distance_cm, btn: i_button_pressed});
                ticks_taken++;
                if ($urandom_range(0, 63) == 0)
                    tx_burst = ~tx_burst;
            end
            if (!i_valid || o_ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_valid <= 1'b0;
                end else if (tick_q.size() > 0) begin
                    t = tick_q.pop_front();
                    i_valid          <= 1'b1;
                    i_distance_cm    <= t.cm;
                    i_button_pressed <= t.btn;
                    tx_gap = pick_gap(tx_burst);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stalls the output side and checks each digit word in order.
    int unsigned rx_stall = 0;
    bit          rx_burst = 1'b0;

    always @(posedge i_clk) begin
        t_digit d;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                digits_seen++;
                if (digit_q.size() == 0) begin
                    $error("digit word with no expectation pending: value %0d select %0d %s",
                           o_digit_value, o_digit_select,
                           o_in_inches ? "inch" : "cm");
                    n_err++;
                end else begin
                    d = digit_q.pop_front();
                    if (d.inch)
                        inch_digits++;
                    if (o_digit_value !== d.value) begin
                        $error("digit_value: expected %0d, got %0d", d.value, o_digit_value);
                        n_err++;
                    end
                    if (o_digit_select !== d.sel) begin
                        $error("digit_select: expected %0d, got %0d", d.sel, o_digit_select);
                        n_err++;
                    end
                    if (o_in_inches !== d.inch) begin
                        $error("in_inches: expected %0d, got %0d", d.inch, o_in_inches);
                        n_err++;
                    end
                end
                if ($urandom_range(0, 63) == 0)
                    rx_burst = ~rx_burst;
                rx_stall = pick_gap(rx_burst);
            end
            if (rx_stall > 0) begin
                rx_stall--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Watchdog: gives up when neither side has moved a word for too long.
    int unsigned quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("distance_display_mux_with_unit_toggle_tb NOT OK");
            $finish;
        end
    end

    task automatic queue_tick(input logic [DIST_W-1:0] cm, input logic btn);
        tick_q.push_back('{cm: cm, btn: btn});
        ticks_queued++;
    endtask

    function automatic logic [DIST_W-1:0] pick_dist();
        case ($urandom_range(0, 9))
            0:       return DIST_W'($urandom_range(0, 16383));
            1:       return DIST_W'($urandom_range(9990, 10010));
            2:       return DIST_W'($urandom_range(0, 99));
            default: return DIST_W'($urandom_range(0, 9999));
        endcase
    endfunction

    // Waits until every tick is taken and every digit has come out, then lets
    // the pipeline go quiet before the caller touches a register.
    task automatic drain();
        while (ticks_taken != ticks_queued || digit_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [PERIOD_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_writes++;
    endtask

    initial begin
        int unsigned         sp;
        int unsigned         bp;
        int unsigned         hold;
        logic                level;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset periods: the button is held across its first sample at tick 200,
        // while the distance is never latched and the display stays at zero.
        for (int i = 0; i < 230; i++)
            queue_tick(pick_dist(), (i >= 195 && i <= 205));
        drain();

        // Zero periods make both tasks run on every tick, so each distance
        // is latched and each press is sampled right away.
        write_reg(ddmut_pkg::REG_SONAR_PERIOD, '0);
        write_reg(ddmut_pkg::REG_BUTTON_PERIOD, '0);
        queue_tick(14'd0, 1'b0);
        queue_tick(14'd9999, 1'b0);
        queue_tick(14'd10000, 1'b0);
        queue_tick(14'd16383, 1'b0);
        queue_tick(14'd1234, 1'b1);
        queue_tick(14'd1234, 1'b1);
        queue_tick(14'd5678, 1'b0);
        queue_tick(14'd9999, 1'b0);
        queue_tick(14'd16383, 1'b0);
        queue_tick(14'd1, 1'b0);
        queue_tick(14'd2, 1'b1);
        queue_tick(14'd2, 1'b1);
        queue_tick(14'd13, 1'b0);
        queue_tick(14'd8191, 1'b0);
        queue_tick(14'd4095, 1'b0);
        queue_tick(14'd9876, 1'b0);
        queue_tick(14'd127, 1'b1);
        queue_tick(14'd127, 1'b1);
        queue_tick(14'd9998, 1'b0);
        queue_tick(14'd9999, 1'b0);
        queue_tick(14'd0, 1'b0);
        queue_tick(14'd1270, 1'b0);
        drain();

        // Random phases, each with its own pair of periods. Button presses are
        // held for runs of random length so that many of them span a sample.
        level = 1'b0;
        for (int p = 0; p < 10; p++) begin
            case (p)
                0:       begin sp = 1;    bp = 1;    end
                1:       begin sp = 0;    bp = 3;    end
                2:       begin sp = 1023; bp = 1023; end
                3:       begin sp = 5;    bp = 0;    end
                7:       begin sp = $urandom_range(0, 1023); bp = $urandom_range(0, 1023); end
                8:       begin sp = 2;    bp = 7;    end
                9:       begin sp = 1023; bp = 1;    end
                default: begin sp = $urandom_range(1, 40); bp = $urandom_range(1, 40); end
            endcase
            write_reg(ddmut_pkg::REG_SONAR_PERIOD, PERIOD_W'(sp));
            write_reg(ddmut_pkg::REG_BUTTON_PERIOD, PERIOD_W'(bp));
            hold = 0;
            for (int i = 0; i < 80; i++) begin
                if (hold == 0) begin
                    level = ~level;
                    hold  = $urandom_range(1, bp + 3);
                end
                hold--;
                queue_tick(pick_dist(), level);
            end
            drain();
        end

        $display("%0d ticks sent, %0d digits checked (%0d shown in inches)",
                 ticks_taken, digits_seen, inch_digits);
        $display("%0d unit toggles predicted, %0d register writes over 11 period settings",
                 unit_toggles, cfg_writes);
        if (n_err == 0)
            $display("distance_display_mux_with_unit_toggle_tb OK");
        else
            $display("distance_display_mux_with_unit_toggle_tb NOT OK");
        $finish;
    end

endmodule
